/* rtl/core/gsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_pkg
// Types, constants and the per-stage datapath function of the 3x3 grid
// symmetry canonical-form check pipeline.
// ----------------------------------------------------------------------------
package gsc_pkg;

    localparam int NUM_CELLS  = 9;
    localparam int NUM_SYM    = 7;
    localparam int DIGIT_W    = 7;
    localparam int INDEX_W    = 64;
    localparam int NUM_POW    = NUM_CELLS + 1;

    // Stage plan: power build, range check, digit long division, Horner, compare
    localparam int ST_RANGE   = NUM_CELLS;
    localparam int ST_DIV0    = ST_RANGE + 1;
    localparam int DIV_STEPS  = NUM_CELLS * DIGIT_W;
    localparam int ST_HORNER0 = ST_DIV0 + DIV_STEPS;
    localparam int ST_CMP     = ST_HORNER0 + NUM_CELLS;
    localparam int NUM_STAGES = ST_CMP + 1;

    // Source cell for each image cell, one row per symmetry
    localparam logic [3:0] SYM_MAP [0:NUM_SYM-1][0:NUM_CELLS-1] = '{
        '{4'd6, 4'd7, 4'd8, 4'd3, 4'd4, 4'd5, 4'd0, 4'd1, 4'd2},
        '{4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0},
        '{4'd2, 4'd1, 4'd0, 4'd5, 4'd4, 4'd3, 4'd8, 4'd7, 4'd6},
        '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8},
        '{4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6},
        '{4'd8, 4'd5, 4'd2, 4'd7, 4'd4, 4'd1, 4'd6, 4'd3, 4'd0},
        '{4'd6, 4'd3, 4'd0, 4'd7, 4'd4, 4'd1, 4'd8, 4'd5, 4'd2}
    };

    typedef struct packed {
        logic [INDEX_W-1:0]                   idx;
        logic [DIGIT_W-1:0]                   radix;
        logic [NUM_POW-1:0][INDEX_W-1:0]      pw;
        logic [INDEX_W-1:0]                   rem;
        logic [NUM_CELLS-1:0][DIGIT_W-1:0]    dig;
        logic [NUM_SYM-1:0][INDEX_W-1:0]      img;
        logic                                 oor;
        logic                                 can;
    } gsc_item_t;

    // Work done by stage g; dj/db pick digit and quotient bit, hh the Horner step
    function automatic gsc_item_t gsc_stage(input int g, input int dj, input int db,
                                            input int hh, input gsc_item_t a);
        gsc_item_t              b;
        logic [INDEX_W+6:0]     trial;
        logic                   smaller;
        b       = a;
        trial   = '0;
        smaller = 1'b0;
        if (g >= 1 && g < ST_RANGE) begin
            b.pw[g+1] = INDEX_W'(a.pw[g] * {{(INDEX_W-DIGIT_W){1'b0}}, a.radix});
        end else if (g == ST_RANGE) begin
            b.oor = (a.idx >= a.pw[NUM_CELLS]);
        end else if (g >= ST_DIV0 && g < ST_HORNER0) begin
            // One restoring step: test quotient bit db of digit dj
            trial = {7'b0, a.pw[dj]} << db;
            if ({7'b0, a.rem} >= trial) begin
                b.rem        = a.rem - trial[INDEX_W-1:0];
                b.dig[dj][db] = 1'b1;
            end
        end else if (g >= ST_HORNER0 && g < ST_CMP) begin
            for (int k = 0; k < NUM_SYM; k++) begin
                b.img[k] = INDEX_W'(a.img[k] * {{(INDEX_W-DIGIT_W){1'b0}}, a.radix})
                         + {{(INDEX_W-DIGIT_W){1'b0}},
                            a.dig[SYM_MAP[k][NUM_CELLS-1-hh]]};
            end
        end else if (g == ST_CMP) begin
            for (int k = 0; k < NUM_SYM; k++) begin
                smaller = smaller | (a.img[k] < a.idx);
            end
            b.can = !a.oor && !smaller;
        end
        return b;
    endfunction

endpackage

/* rtl/core/grid_symmetry_canonical_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_symmetry_canonical_check
// Canonical-form check of a 3x3 grid index under the square's symmetries.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; the pipeline moves as one and holds
//   whenever the output register is full and not taken.
// Long division of the index by radix powers takes 63 of the pipeline stages.
// Reset: synchronous active-low aresetn clears all valid bits and sets
//   class_count to 4.
module grid_symmetry_canonical_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] grid_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] is_canonical, [1] out_of_range, [7:2] zero
);
    import gsc_pkg::*;

    logic [DIGIT_W-1:0]    class_count_reg;
    logic [NUM_STAGES-1:0] valid_reg;
    gsc_item_t             st_reg  [NUM_STAGES];
    gsc_item_t             st_next [NUM_STAGES];
    gsc_item_t             in_item;
    logic                  advance;

    // Hold the whole pipe while the output register waits
    assign advance  = !valid_reg[NUM_STAGES-1] || m_tready;
    assign s_tready = advance;

    // Build the entry item: radix zero acts as radix one
    always_comb begin
        in_item       = '0;
        in_item.idx   = s_tdata;
        in_item.rem   = s_tdata;
        in_item.radix = (class_count_reg == '0) ? DIGIT_W'(1) : class_count_reg;
        in_item.pw[0] = INDEX_W'(1);
        in_item.pw[1] = {{(INDEX_W-DIGIT_W){1'b0}}, in_item.radix};
    end

    // Stage datapath
    for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
        localparam int DT = (g >= ST_DIV0 && g < ST_HORNER0) ? g - ST_DIV0 : 0;
        localparam int DJ = NUM_CELLS - 1 - DT / DIGIT_W;
        localparam int DB = DIGIT_W - 1 - DT % DIGIT_W;
        localparam int HH = (g >= ST_HORNER0 && g < ST_CMP) ? g - ST_HORNER0 : 0;
        if (g == 0) begin : g_first
            assign st_next[g] = gsc_stage(g, DJ, DB, HH, in_item);
        end else begin : g_rest
            assign st_next[g] = gsc_stage(g, DJ, DB, HH, st_reg[g-1]);
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            class_count_reg <= DIGIT_W'(4);
        end else if (cfg_wr_en) begin
            class_count_reg <= cfg_wr_data;
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[NUM_STAGES-2:0], s_tvalid};
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int g = 0; g < NUM_STAGES; g++) begin
                st_reg[g] <= st_next[g];
            end
        end
    end

    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = {6'b0, st_reg[NUM_STAGES-1].oor, st_reg[NUM_STAGES-1].can};

endmodule

/* rtl/core/gsc_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_check
// Port-level checks for the grid symmetry canonical-form check block.
// ----------------------------------------------------------------------------
module gsc_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);
    // Hold a stalled result
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // Out-of-range index is never canonical
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("canonical and out of range together");

    // Reset empties the pipe
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Free slot at the output lets a request in
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("request blocked with empty output");

endmodule

bind grid_symmetry_canonical_check gsc_check u_gsc_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
